FILE: design/cca_pkg.sv
// shared types, codes and helper functions for the csma-ca backoff engine
package cca_pkg;

	typedef enum logic [1:0] {
		FN_TICK  = 2'd0,
		FN_START = 2'd1,
		FN_SEED  = 2'd2,
		FN_DRAW  = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_IDLE      = 2'd0,
		ST_BACKOFF   = 2'd1,
		ST_CLEAR     = 2'd2,
		ST_EXHAUSTED = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		REG_MIN_EXPONENT = 2'd0,
		REG_MAX_EXPONENT = 2'd1,
		REG_MAX_BACKOFFS = 2'd2,
		REG_UNIT_TICKS   = 2'd3
	} reg_index_t;

	localparam int CfgDataWidth = 16;
	localparam int RemWidth     = 24;

	localparam logic [3:0]  MinExponentReset = 4'd3;
	localparam logic [3:0]  MaxExponentReset = 4'd5;
	localparam logic [2:0]  MaxBackoffsReset = 3'd4;
	localparam logic [15:0] UnitTicksReset   = 16'd20;
	localparam logic [15:0] LfsrReset        = 16'h0001;

	typedef struct packed {
		func_t       func;
		logic        cca_clear;
		logic [15:0] seed;
	} req_t;

	typedef struct packed {
		status_t     status;
		logic [7:0]  random_byte;
		logic [3:0]  attempts;
		logic [3:0]  exponent;
	} rsp_t;

	// fibonacci step, taps 15 14 12 3
	function automatic logic [15:0] lfsr_next(input logic [15:0] cur);
		return {cur[14:0], cur[15] ^ cur[14] ^ cur[12] ^ cur[3]};
	endfunction

	// 2^e - 1, whole byte from eight up
	function automatic logic [7:0] backoff_mask(input logic [3:0] e);
		logic [8:0] full;
		full = (9'h001 << e[2:0]) - 9'h001;
		return (e >= 4'd8) ? 8'hff : full[7:0];
	endfunction

endpackage

FILE: design/cca_if.sv
// valid/ready channel interfaces for requests and results
interface cca_req_if;
	logic          valid;
	logic          ready;
	cca_pkg::req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface cca_rsp_if;
	logic          valid;
	logic          ready;
	cca_pkg::rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: design/csma_ca_backoff_engine.sv
// csma-ca backoff engine top level: request register, update logic, result register
//
// usage
//   req carries one request per handshake: func (tick, start, load seed, draw),
//   cca_clear (sampled only by the tick that finds the delay used up) and seed.
//   rsp returns exactly one result per request, in order: status, random_byte,
//   attempts and exponent as they stand after that request.
//   cfg_we / cfg_index / cfg_wdata write min_exponent, max_exponent,
//   max_backoffs and unit_ticks; write them only while no request is in flight.
// timing
//   a request waits in the request register; its result goes to the result
//   register when it advances. one request is taken every cycle unless rsp is
//   held; the request register and the result register set the pipeline depth.
// reset
//   arst_n clears both stages, loads the register defaults and sets the lfsr to 1.
// stall
//   while rsp is held, the request register keeps one more request and then
//   req.ready drops until the result is taken.
module csma_ca_backoff_engine (
	input  logic                              clk,
	input  logic                              arst_n,
	cca_req_if.sink                           req,
	cca_rsp_if.source                         rsp,
	input  logic                              cfg_we,
	input  cca_pkg::reg_index_t               cfg_index,
	input  logic [cca_pkg::CfgDataWidth-1:0]  cfg_wdata
);

	// configuration
	logic [3:0]  min_exp_q;
	logic [3:0]  max_exp_q;
	logic [2:0]  max_backoffs_q;
	logic [15:0] unit_ticks_q;

	// engine state
	logic [15:0]                  lfsr_q;
	logic                         busy_q;
	logic [3:0]                   exp_q;
	logic [3:0]                   cnt_q;
	logic [cca_pkg::RemWidth-1:0] rem_q;

	// pipeline
	logic          valid_s1;
	cca_pkg::req_t req_s1;
	logic          rsp_valid_q;
	cca_pkg::rsp_t rsp_q;
	logic          advance;

	// next state
	logic [15:0]                  lfsr_n;
	logic                         busy_n;
	logic [3:0]                   exp_n;
	logic [3:0]                   cnt_n;
	logic [cca_pkg::RemWidth-1:0] rem_n;
	cca_pkg::status_t             status_n;
	logic                         load;
	logic [4:0]                   exp_inc;
	logic [3:0]                   exp_sat;
	logic [7:0]                   pick;
	logic [15:0]                  lfsr_stepped;

	assign advance   = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_exp_q      <= cca_pkg::MinExponentReset;
			max_exp_q      <= cca_pkg::MaxExponentReset;
			max_backoffs_q <= cca_pkg::MaxBackoffsReset;
			unit_ticks_q   <= cca_pkg::UnitTicksReset;
		end else if (cfg_we) begin
			case (cfg_index)
				cca_pkg::REG_MIN_EXPONENT: min_exp_q <= cfg_wdata[3:0];
				cca_pkg::REG_MAX_EXPONENT: max_exp_q <= cfg_wdata[3:0];
				cca_pkg::REG_MAX_BACKOFFS: max_backoffs_q <= cfg_wdata[2:0];
				cca_pkg::REG_UNIT_TICKS:   unit_ticks_q <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	assign exp_inc      = {1'b0, exp_q} + 5'd1;
	assign exp_sat      = (exp_inc > {1'b0, max_exp_q}) ? max_exp_q : exp_inc[3:0];
	assign lfsr_stepped = cca_pkg::lfsr_next(lfsr_q);
	assign pick         = lfsr_stepped[7:0] & cca_pkg::backoff_mask(exp_n);

	always_comb begin
		lfsr_n   = lfsr_q;
		busy_n   = busy_q;
		exp_n    = exp_q;
		cnt_n    = cnt_q;
		rem_n    = rem_q;
		load     = 1'b0;
		status_n = busy_q ? cca_pkg::ST_BACKOFF : cca_pkg::ST_IDLE;
		case (req_s1.func)
			cca_pkg::FN_TICK: begin
				if (!busy_q) begin
					status_n = cca_pkg::ST_IDLE;
				end else if (rem_q != '0) begin
					rem_n    = rem_q - cca_pkg::RemWidth'(1);
					status_n = cca_pkg::ST_BACKOFF;
				end else if (req_s1.cca_clear) begin
					busy_n   = 1'b0;
					status_n = cca_pkg::ST_CLEAR;
				end else begin
					exp_n = exp_sat;
					cnt_n = cnt_q + 4'd1;
					if (cnt_n > {1'b0, max_backoffs_q}) begin
						busy_n   = 1'b0;
						rem_n    = '0;
						status_n = cca_pkg::ST_EXHAUSTED;
					end else begin
						load     = 1'b1;
						status_n = cca_pkg::ST_BACKOFF;
					end
				end
			end
			cca_pkg::FN_START: begin
				exp_n    = min_exp_q;
				cnt_n    = 4'd0;
				busy_n   = 1'b1;
				load     = 1'b1;
				status_n = cca_pkg::ST_BACKOFF;
			end
			cca_pkg::FN_SEED: lfsr_n = req_s1.seed;
			cca_pkg::FN_DRAW: lfsr_n = lfsr_stepped;
			default: ;
		endcase
		if (load) begin
			if (exp_n != 4'd0) begin
				lfsr_n = lfsr_stepped;
				rem_n  = cca_pkg::RemWidth'(pick) * cca_pkg::RemWidth'(unit_ticks_q);
			end else begin
				rem_n = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lfsr_q <= cca_pkg::LfsrReset;
			busy_q <= 1'b0;
			exp_q  <= 4'd0;
			cnt_q  <= 4'd0;
			rem_q  <= '0;
		end else if (advance) begin
			lfsr_q <= lfsr_n;
			busy_q <= busy_n;
			exp_q  <= exp_n;
			cnt_q  <= cnt_n;
			rem_q  <= rem_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (req.ready) begin
				valid_s1 <= req.valid;
			end
			if (advance) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_s1 <= req.data;
		end
		if (advance) begin
			rsp_q.status      <= status_n;
			rsp_q.random_byte <= lfsr_n[7:0];
			rsp_q.attempts    <= cnt_n;
			rsp_q.exponent    <= exp_n;
		end
	end

`ifndef SYNTHESIS
	a_done_goes_idle: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (status_n == cca_pkg::ST_CLEAR || status_n == cca_pkg::ST_EXHAUSTED)
		|=> !busy_q)
		else $error("attempt finished but engine still busy");

	a_idle_no_delay: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> rem_q == '0)
		else $error("delay pending while idle");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 4'd8)
		else $error("busy count out of range");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && rsp_valid_q && !rsp.ready |-> !req.ready)
		else $error("request taken with both stages full");
`endif

endmodule
